[rtl/fault_change_event_logger_top_defines.svh]
// ----------------------------------------------------------------------------
// Fault change event logger assertion macros
// Clocked property checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef FAULT_CHANGE_EVENT_LOGGER_TOP_DEFINES_SVH
`define FAULT_CHANGE_EVENT_LOGGER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every rising edge outside reset.
`define FCEL_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true at a rising edge outside reset.
`define FCEL_ASSERT_NEVER(name, clk, rst_n, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FCEL_ASSERT(name, clk, rst_n, prop, msg)
`define FCEL_ASSERT_NEVER(name, clk, rst_n, expr, msg)
`endif

`endif

[rtl/fcel_pkg.sv]
// ----------------------------------------------------------------------------
// Fault change event logger package
// Shared widths, request codes and the log slot layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcel_pkg;

	// Default configuration of the log.
	localparam int DEF_LOG_DEPTH = 64;
	localparam int DEF_MASK_BITS = 32;

	// Fixed field widths.
	localparam int FIELD_BITS  = 32;
	localparam int ID_W        = 5;
	localparam int RIDX_W      = 6;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 40;

	// Bit positions inside the input beat.
	localparam int IN_MASK_LSB = 0;
	localparam int IN_TIME_LSB = 32;
	localparam int IN_RIDX_LSB = 64;

	// Request kinds carried on s_tuser.
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_READ   = 1'b1;

	// One log slot as stored in the memory.
	typedef struct packed {
		logic                  valid;
		logic [FIELD_BITS-1:0] stamp;
		logic [ID_W-1:0]       id;
		logic                  level;
	} slot_t;

endpackage

[rtl/fault_change_event_logger_top.sv]
// Reads: a read request latches its slot into the registered memory read data, then moves it
// into the output register once that register is free. On a sample the events leave in
// ascending bit order; the serial bit scan covers one bit position per cycle, stalling on a
// changed bit while the output register is full, up to the highest changed bit. No new request is taken until it ends.
// Reset: asynchronous, active low; afterwards a clearing pass over every slot zeroes the
// slot valid bits in the log memory while s_tready stays low.
// ----------------------------------------------------------------------------
// Fault change event logger
// Logs every changed fault bit into a ring log memory and serves slot reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fault_change_event_logger_top_defines.svh"

module fault_change_event_logger_top #(
	parameter int LOG_DEPTH = fcel_pkg::DEF_LOG_DEPTH,
	parameter int MASK_BITS = fcel_pkg::DEF_MASK_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// fault_mask[31:0], time_sec[63:32], read_index[69:64], zero fill
	input  logic [fcel_pkg::IN_TDATA_W-1:0]    s_tdata,
	// req_type[0]
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// event_time[31:0], event_id[36:32], event_active[37], zero fill
	output logic [fcel_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// entry_valid[0]
	output logic                               m_tuser,
	// last_of_run
	output logic                               m_tlast
);
	import fcel_pkg::*;

	localparam int SCAN_BITS = (MASK_BITS < FIELD_BITS) ? MASK_BITS : FIELD_BITS;
	localparam int AW        = $clog2(LOG_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(LOG_DEPTH - 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_RD_OUT
	} state_t;

	state_t                state_q;
	logic [AW-1:0]         clr_q;
	logic [AW-1:0]         head_q;
	logic [SCAN_BITS-1:0]  prev_q;
	logic [SCAN_BITS-1:0]  rem_q;
	logic [SCAN_BITS-1:0]  lvl_q;
	logic [ID_W-1:0]       bit_q;
	logic [FIELD_BITS-1:0] time_q;
	logic                  in_range_q;
	logic                  m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                  m_tuser_q;
	logic                  m_tlast_q;
	slot_t                 rd_q;

	// Log memory.
	slot_t                 log_mem [LOG_DEPTH];

	logic                  accept;
	logic                  out_free;
	logic [SCAN_BITS-1:0]  in_mask;
	logic [SCAN_BITS-1:0]  in_changed;
	logic [31:0]           ridx_ext;
	logic                  in_range;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  emit;
	logic                  step;
	logic [SCAN_BITS-1:0]  rem_next;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	slot_t                 wr_data;
	logic [AW-1:0]         head_next;

	// Input decode.
	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;
	assign in_mask    = s_tdata[IN_MASK_LSB +: SCAN_BITS];
	assign in_changed = in_mask ^ prev_q;
	assign ridx_ext   = 32'(s_tdata[IN_RIDX_LSB +: RIDX_W]);
	assign in_range   = ridx_ext < 32'(LOG_DEPTH);
	assign rd_en      = accept && (s_tuser == REQ_READ);
	assign rd_addr    = in_range ? ridx_ext[AW-1:0] : '0;

	// Serial scan control: one bit position per cycle, stalled on a changed bit by a full output register.
	assign emit      = (state_q == ST_SCAN) && rem_q[0] && out_free;
	assign step      = (state_q == ST_SCAN) && (!rem_q[0] || out_free);
	assign rem_next  = rem_q >> 1;
	assign head_next = (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);

	// Memory write: clearing pass or a logged event at the head.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = head_q;
		wr_data = '0;
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
		end else if (emit) begin
			wr_en         = 1'b1;
			wr_data.valid = 1'b1;
			wr_data.stamp = time_q;
			wr_data.id    = bit_q;
			wr_data.level = lvl_q[0];
		end
	end

	// Synchronous log memory with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			log_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= log_mem[rd_addr];
		end
	end

	// Control state machine and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			head_q     <= '0;
			prev_q     <= '0;
			rem_q      <= '0;
			lvl_q      <= '0;
			bit_q      <= '0;
			time_q     <= '0;
			in_range_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
			m_tlast_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_SLOT) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == REQ_READ) begin
							in_range_q <= in_range;
							state_q    <= ST_RD_OUT;
						end else begin
							prev_q <= in_mask;
							rem_q  <= in_changed;
							lvl_q  <= in_mask;
							bit_q  <= '0;
							time_q <= s_tdata[IN_TIME_LSB +: FIELD_BITS];
							if (in_changed != '0) begin
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_SCAN: begin
					if (emit) begin
						head_q     <= head_next;
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {2'b00, lvl_q[0], bit_q, time_q};
						m_tuser_q  <= 1'b1;
						m_tlast_q  <= (rem_next == '0);
					end
					if (step) begin
						rem_q <= rem_next;
						lvl_q <= lvl_q >> 1;
						bit_q <= bit_q + ID_W'(1);
						if (rem_next == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_RD_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tlast_q  <= 1'b1;
						if (in_range_q && rd_q.valid) begin
							m_tdata_q <= {2'b00, rd_q.level, rd_q.id, rd_q.stamp};
							m_tuser_q <= 1'b1;
						end else begin
							m_tdata_q <= '0;
							m_tuser_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// Checks on the control logic.
	`FCEL_ASSERT_NEVER(a_no_beat_in_clear, clk, arst_n, (state_q == ST_CLEAR) && m_tvalid_q, "result beat during clearing pass")
	`FCEL_ASSERT(a_event_write_emits, clk, arst_n, emit |=> (m_tvalid_q && m_tuser_q), "logged event not presented")
	`FCEL_ASSERT(a_read_single_last, clk, arst_n, ((state_q == ST_RD_OUT) && out_free) |=> (m_tvalid_q && m_tlast_q), "read result not a single last beat")
	`FCEL_ASSERT(a_head_in_range, clk, arst_n, 32'(head_q) < 32'(LOG_DEPTH), "log head beyond log depth")

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fault change event logger testbench
// Drives fault mask samples and log slot reads into the logger and checks every
// returned event against a predictor of the ring log, under random stalls.
// ----------------------------------------------------------------------------

module tb;
	import fcel_pkg::*;

	localparam int DEPTH        = DEF_LOG_DEPTH;
	localparam int MASK_W       = DEF_MASK_BITS;
	localparam int RANDOM_ITEMS = 310;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 40;

	// Positions of the fields inside the result beat.
	localparam int EV_TIME_LSB   = 0;
	localparam int EV_ID_LSB     = 32;
	localparam int EV_ACTIVE_BIT = 37;

	// One event as it should leave the block.
	typedef struct packed {
		logic [FIELD_BITS-1:0] stamp;
		logic [ID_W-1:0]       id;
		logic                  level;
		logic                  valid;
		logic                  last;
	} log_event_t;

	// Ring log predictor together with the queue of events still due.
	class event_log_tracker;
		logic [MASK_W-1:0]     prev_mask;
		int                    head;
		logic                  slot_valid [DEPTH];
		logic [FIELD_BITS-1:0] slot_stamp [DEPTH];
		logic [ID_W-1:0]       slot_id [DEPTH];
		logic                  slot_level [DEPTH];
		log_event_t            due_events [$];
		int                    mismatches;

		function new();
			prev_mask = '0;
			head = 0;
			mismatches = 0;
			foreach (slot_valid[i]) begin
				slot_valid[i] = 1'b0;
				slot_stamp[i] = '0;
				slot_id[i] = '0;
				slot_level[i] = 1'b0;
			end
		endfunction

		function int pending();
			return due_events.size();
		endfunction

		// Update the log for one accepted request and queue the events it causes.
		function void log_request(logic req, logic [MASK_W-1:0] mask,
				logic [FIELD_BITS-1:0] stamp, logic [RIDX_W-1:0] idx);
			log_event_t ev;
			log_event_t held;
			logic [MASK_W-1:0] changed;
			bit have_held;
			ev = '0;
			held = '0;
			have_held = 0;
			if (req == REQ_READ) begin
				ev.last = 1'b1;
				if (idx < DEPTH && slot_valid[idx]) begin
					ev.stamp = slot_stamp[idx];
					ev.id = slot_id[idx];
					ev.level = slot_level[idx];
					ev.valid = 1'b1;
				end
				due_events.push_back(ev);
			end else begin
				changed = mask ^ prev_mask;
				for (int b = 0; b < MASK_W; b++) begin
					if (changed[b]) begin
						slot_stamp[head] = stamp;
						slot_id[head] = b[ID_W-1:0];
						slot_level[head] = mask[b];
						slot_valid[head] = 1'b1;
						head = (head == DEPTH - 1) ? 0 : head + 1;
						// The previous event of this sample is known not to be the last.
						if (have_held)
							due_events.push_back(held);
						held.stamp = stamp;
						held.id = b[ID_W-1:0];
						held.level = mask[b];
						held.valid = 1'b1;
						held.last = 1'b0;
						have_held = 1;
					end
				end
				if (have_held) begin
					held.last = 1'b1;
					due_events.push_back(held);
				end
				prev_mask = mask;
			end
		endfunction

		task report_mismatch(string field, logic [FIELD_BITS-1:0] got,
				logic [FIELD_BITS-1:0] want);
			$display("mismatch on %s: got %0h, expected %0h", field, got, want);
			mismatches++;
		endtask

		// Compare one accepted result beat with the oldest due event.
		task match_event(logic [OUT_TDATA_W-1:0] data, logic valid, logic last);
			log_event_t want;
			if (due_events.size() == 0) begin
				report_mismatch("unexpected result", data[FIELD_BITS-1:0], '0);
				return;
			end
			want = due_events.pop_front();
			if (data[EV_TIME_LSB +: FIELD_BITS] !== want.stamp)
				report_mismatch("event_time", data[EV_TIME_LSB +: FIELD_BITS], want.stamp);
			if (data[EV_ID_LSB +: ID_W] !== want.id)
				report_mismatch("event_id", FIELD_BITS'(data[EV_ID_LSB +: ID_W]),
					FIELD_BITS'(want.id));
			if (data[EV_ACTIVE_BIT] !== want.level)
				report_mismatch("event_active", FIELD_BITS'(data[EV_ACTIVE_BIT]),
					FIELD_BITS'(want.level));
			if (valid !== want.valid)
				report_mismatch("entry_valid", FIELD_BITS'(valid), FIELD_BITS'(want.valid));
			if (last !== want.last)
				report_mismatch("last_of_run", FIELD_BITS'(last), FIELD_BITS'(want.last));
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;

	event_log_tracker board = new();
	bit calm = 1'b1;
	logic [FIELD_BITS-1:0] clock_sec = '0;

	always #4 clk = ~clk;

	fault_change_event_logger_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// Idle length: mostly none, sometimes a few cycles, rarely a long stretch.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 70)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Choose a slot that has been written, so most reads return a logged event.
	function automatic logic [RIDX_W-1:0] pick_logged_slot();
		int start;
		start = $urandom_range(0, DEPTH - 1);
		for (int n = 0; n < DEPTH; n++) begin
			if (board.slot_valid[(start + n) % DEPTH])
				return RIDX_W'((start + n) % DEPTH);
		end
		return '0;
	endfunction

	// Offer one request beat, wait for it to be taken, then maybe idle.
	task automatic send_request(input logic req, input logic [MASK_W-1:0] mask,
			input logic [FIELD_BITS-1:0] stamp, input logic [RIDX_W-1:0] idx);
		logic [IN_TDATA_W-1:0] beat;
		int gap;
		beat = '0;
		beat[IN_MASK_LSB +: MASK_W] = mask;
		beat[IN_TIME_LSB +: FIELD_BITS] = stamp;
		beat[IN_RIDX_LSB +: RIDX_W] = idx;
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= beat;
		@(posedge clk);
		while (s_tready !== 1'b1)
			@(posedge clk);
		board.log_request(req, mask, stamp, idx);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic sample(input logic [MASK_W-1:0] mask, input logic [FIELD_BITS-1:0] stamp);
		send_request(REQ_SAMPLE, mask, stamp, RIDX_W'($urandom()));
	endtask

	task automatic read_slot(input logic [RIDX_W-1:0] idx);
		send_request(REQ_READ, $urandom(), $urandom(), idx);
	endtask

	// Hold the request side until every due event has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (board.pending() > 0);
	endtask

	// Result side: check accepted beats and stall at random.
	initial begin : result_sink
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1)
				board.match_event(m_tdata, m_tuser, m_tlast);
			if (stall == 0)
				stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run when no beat moves on either side for too long.
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
					(m_tvalid === 1'b1 && m_tready === 1'b1))
				idle = 0;
			else
				idle++;
		end
		$display("simulation failed");
		$finish;
	end

	// Main sequence: reset, directed cases, then random traffic.
	initial begin : stimulus
		logic [MASK_W-1:0] mask;
		int r;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, first without idling.
		read_slot(6'd5);
		sample('0, '0);
		sample(32'h0000_0001, '0);
		read_slot(6'd0);
		read_slot(6'd40);
		sample('1, '1);
		sample('0, 32'h8000_0000);
		calm = 1'b0;
		sample('1, 32'h0000_1234);
		sample('1, 32'h0000_1235);
		sample(32'h8000_0000, 32'h0000_1236);
		sample(32'h8000_0001, 32'h7FFF_FFFF);
		read_slot(6'd63);
		read_slot(6'd0);
		read_slot(6'd32);
		read_slot(6'h2A);
		read_slot(6'h15);
		sample(32'h5555_5555, 32'hAAAA_AAAA);
		sample(32'hAAAA_AAAA, 32'h5555_5555);
		sample(32'hAAAA_AAAA, 32'h5555_5556);
		read_slot(6'd31);
		wait_drained();

		// Random part: mostly small changes against the previous mask.
		clock_sec = 32'h0001_0000;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 29) == 0)
				calm = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 49) == 0)
				wait_drained();
			if ($urandom_range(0, 19) == 0)
				clock_sec = $urandom();
			else
				clock_sec = clock_sec + $urandom_range(0, 5);
			if ($urandom_range(0, 9) < 4) begin
				read_slot(pick_logged_slot());
			end else begin
				r = $urandom_range(0, 99);
				mask = board.prev_mask;
				if (r < 10)
					mask = board.prev_mask;
				else if (r < 30)
					mask = $urandom();
				else if (r < 34)
					mask = ~board.prev_mask;
				else
					repeat ($urandom_range(1, 4))
						mask = mask ^ (MASK_W'(1) << $urandom_range(0, MASK_W - 1));
				sample(mask, clock_sec);
			end
		end

		// Let every due event arrive, then allow the block to settle.
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/fcel_pkg.sv
rtl/fault_change_event_logger_top.sv
tb/sv/tb.sv
